// ===== src/fit_partition_allocator_unit_defines.svh =====
// assertion macros for the fit partition allocator checker
// expects signals clk and rst_n in the scope of use
`ifndef FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FPA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fit allocator port check failed");

// next-cycle implication, disabled during reset
`define FPA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fit allocator port check failed");

`endif

// ===== src/fpa_pkg.sv =====
// shared types, codes and microcode rom of the fit partition allocator
// no dependencies
package fpa_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // fit modes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // configuration register indexes
    localparam logic CFG_FIT_MODE = 1'b0;
    localparam logic CFG_BLOCKS   = 1'b1;

    localparam logic [19:0] WASTE_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  block_index;
        logic [15:0] item_size;
    } in_beat_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  granted_block;
        logic [15:0] block_waste;
        logic [19:0] total_waste;
        logic        any_failed;
        logic [15:0] request_number;
    } out_beat_t;

    // sequencer steps
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_LOAD   = 3'd1;
    localparam step_t STEP_CLEAR  = 3'd2;
    localparam step_t STEP_INIT   = 3'd3;
    localparam step_t STEP_SCAN   = 3'd4;
    localparam step_t STEP_COMMIT = 3'd5;
    localparam step_t STEP_EMIT   = 3'd6;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_ACCEPT,
        JC_EMPTY,
        JC_SCAN_END,
        JC_OUT_FREE
    } jump_cond_t;

    typedef struct packed {
        logic       take_in;
        logic       mem_load;
        logic       totals_clear;
        logic       scan_init;
        logic       scan_step;
        logic       commit;
        logic       emit;
        jump_cond_t cond;
        step_t      target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        w.cond = JC_NEXT;
        w.target = STEP_IDLE;
        case (step)
            STEP_IDLE:
            begin
                w.take_in = 1'b1;
                w.cond    = JC_ACCEPT;
            end
            STEP_LOAD:
            begin
                w.mem_load = 1'b1;
                w.cond     = JC_ALWAYS;
                w.target   = STEP_EMIT;
            end
            STEP_CLEAR:
            begin
                w.totals_clear = 1'b1;
                w.cond         = JC_ALWAYS;
                w.target       = STEP_EMIT;
            end
            STEP_INIT:
            begin
                w.scan_init = 1'b1;
                w.cond      = JC_EMPTY;
                w.target    = STEP_COMMIT;
            end
            STEP_SCAN:
            begin
                w.scan_step = 1'b1;
                w.cond      = JC_SCAN_END;
                w.target    = STEP_COMMIT;
            end
            STEP_COMMIT:
            begin
                w.commit = 1'b1;
                w.cond   = JC_NEXT;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = JC_OUT_FREE;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = JC_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/fit_partition_allocator_unit.sv =====
// allocate: an accepted item passes the init step, the scan loop over min(blocks_in_use,
// NUM_PARTITIONS) entries (one table read per cycle), the commit step and the emit step;
// load and clear pass their own step, then emit; an unused command code goes straight to emit
// a new item is taken only in the idle step, also while a result beat waits in the output reg
// reset: partition table reads as all zero (per-entry valid bits), totals, flag and
// request count cleared, fit_mode = first fit, blocks_in_use = 16
module fit_partition_allocator_unit
    import fpa_pkg::*;
#(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
)
(
    input  logic      clk,
    input  logic      rst_n,

    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,

    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data,

    input  logic      cfg_write_en,
    input  logic      cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
    localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int SUM_W = ((SIZE_BITS > 20) ? SIZE_BITS : 20) + 1;

    // sequencer
    step_t      step_reg;
    step_t      step_next;
    ucode_t     ucode;
    logic       in_fire;
    logic       out_free;
    logic       emit_fire;
    step_t      dispatch_step;

    // configuration
    logic [1:0] fit_mode_reg;
    logic [4:0] blocks_in_use_reg;
    logic [LIM_W-1:0] blocks_wide;
    logic [LIM_W-1:0] limit;

    // latched item
    logic [3:0]           idx_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [31:0]          in_size_wide;
    logic [31:0]          idx_wide;
    logic                 idx_in_range;

    // partition table: payload memory plus valid bits
    logic [SIZE_BITS-1:0] mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] vld_reg;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic                 mem_we;

    // scan state
    logic [LIM_W-1:0]     ptr_reg;
    logic [LIM_W-1:0]     cmp_reg;
    logic                 have_reg;
    logic [SIZE_BITS-1:0] best_size_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SIZE_BITS-1:0] cand;
    logic                 better;
    logic                 take;
    logic                 scan_end;

    // commit arithmetic
    logic [SIZE_BITS-1:0] left;
    logic [31:0]          left_wide;
    logic [31:0]          best_idx_wide;
    logic [SUM_W-1:0]     sum_wide;
    logic [19:0]          waste_sat;

    // totals and result
    logic [19:0] waste_sum_reg;
    logic        failure_reg;
    logic [15:0] req_count_reg;
    logic        res_granted_reg;
    logic [3:0]  res_block_reg;
    logic [15:0] res_waste_reg;
    logic        out_valid_reg;
    out_beat_t   out_data_reg;

    assign ucode     = ucode_rom(step_reg);
    assign in_stall  = !ucode.take_in;
    assign in_fire   = in_valid && ucode.take_in;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = ucode.emit && out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // search count saturates at the table size
    assign blocks_wide = LIM_W'(blocks_in_use_reg);
    assign limit = (blocks_wide > LIM_W'(NUM_PARTITIONS)) ? LIM_W'(NUM_PARTITIONS)
                                                            : blocks_wide;

    assign in_size_wide = 32'(in_data.item_size);
    assign idx_wide     = 32'(idx_reg);
    assign idx_in_range = idx_wide < 32'(NUM_PARTITIONS);
    assign wr_addr      = idx_wide[IDX_W-1:0];
    assign mem_we       = ucode.mem_load && idx_in_range;

    // first word of the scan reads entry zero; past the end reads a harmless entry
    always_comb
    begin
        if (ucode.scan_init || ptr_reg >= LIM_W'(NUM_PARTITIONS))
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = ptr_reg[IDX_W-1:0];
        end
    end

    // an entry never loaded, or already granted, reads as size zero
    assign cand = rd_vld_reg ? rd_data_reg : '0;

    always_comb
    begin
        case (fit_mode_reg)
            FIT_BEST:  better = cand < best_size_reg;
            FIT_WORST: better = cand > best_size_reg;
            default:   better = 1'b0;
        endcase
    end

    assign take     = (cand >= size_reg) && (!have_reg || better);
    assign scan_end = (cmp_reg + LIM_W'(1)) == limit;

    assign left          = best_size_reg - size_reg;
    assign left_wide     = 32'(left);
    assign best_idx_wide = 32'(best_idx_reg);
    assign sum_wide      = SUM_W'(waste_sum_reg) + SUM_W'(left);
    assign waste_sat     = (sum_wide > SUM_W'(WASTE_MAX)) ? WASTE_MAX : sum_wide[19:0];

    always_comb
    begin
        case (in_data.command)
            CMD_LOAD:  dispatch_step = STEP_LOAD;
            CMD_ALLOC: dispatch_step = STEP_INIT;
            CMD_CLEAR: dispatch_step = STEP_CLEAR;
            default:   dispatch_step = STEP_EMIT;
        endcase
    end

    // next step from the jump condition of the current control word
    always_comb
    begin
        case (ucode.cond)
            JC_NEXT:     step_next = step_t'(step_reg + 3'd1);
            JC_ALWAYS:   step_next = ucode.target;
            JC_ACCEPT:   step_next = in_fire ? dispatch_step : step_reg;
            JC_EMPTY:    step_next = (limit == '0) ? ucode.target : step_t'(step_reg + 3'd1);
            JC_SCAN_END: step_next = scan_end ? ucode.target : step_reg;
            JC_OUT_FREE: step_next = out_free ? ucode.target : step_reg;
            default:     step_next = STEP_IDLE;
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= STEP_IDLE;
            fit_mode_reg      <= FIT_FIRST;
            blocks_in_use_reg <= 5'd16;
            vld_reg           <= '0;
            waste_sum_reg     <= '0;
            failure_reg       <= 1'b0;
            req_count_reg     <= '0;
            res_granted_reg   <= 1'b0;
            have_reg          <= 1'b0;
            ptr_reg           <= '0;
            cmp_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_FIT_MODE: fit_mode_reg      <= cfg_data[1:0];
                    CFG_BLOCKS:   blocks_in_use_reg <= cfg_data;
                    default:      fit_mode_reg      <= fit_mode_reg;
                endcase
            end

            if (in_fire)
            begin
                res_granted_reg <= 1'b0;
            end

            if (mem_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end

            if (ucode.totals_clear)
            begin
                waste_sum_reg <= '0;
                failure_reg   <= 1'b0;
                req_count_reg <= '0;
            end

            if (ucode.scan_init)
            begin
                ptr_reg       <= LIM_W'(1);
                cmp_reg       <= '0;
                have_reg      <= 1'b0;
                req_count_reg <= req_count_reg + 16'd1;
            end

            if (ucode.scan_step)
            begin
                ptr_reg <= ptr_reg + LIM_W'(1);
                cmp_reg <= cmp_reg + LIM_W'(1);
                if (take)
                begin
                    have_reg <= 1'b1;
                end
            end

            if (ucode.commit)
            begin
                if (have_reg)
                begin
                    res_granted_reg       <= 1'b1;
                    waste_sum_reg         <= waste_sat;
                    vld_reg[best_idx_reg] <= 1'b0;
                end
                else
                begin
                    failure_reg <= 1'b1;
                end
            end

            // a new beat replaces the one taken at this edge
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            idx_reg       <= in_data.block_index;
            size_reg      <= in_size_wide[SIZE_BITS-1:0];
            res_block_reg <= '0;
            res_waste_reg <= '0;
        end

        if (ucode.scan_step && take)
        begin
            best_size_reg <= cand;
            best_idx_reg  <= cmp_reg[IDX_W-1:0];
        end

        if (ucode.commit && have_reg)
        begin
            res_block_reg <= best_idx_wide[3:0];
            res_waste_reg <= left_wide[15:0];
        end

        if (emit_fire)
        begin
            out_data_reg.granted        <= res_granted_reg;
            out_data_reg.granted_block  <= res_block_reg;
            out_data_reg.block_waste    <= res_waste_reg;
            out_data_reg.total_waste    <= waste_sum_reg;
            out_data_reg.any_failed     <= failure_reg;
            out_data_reg.request_number <= req_count_reg;
        end
    end

    // partition table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= size_reg;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

endmodule

// ===== src/fpa_checker.sv =====
// port-level checks for the fit partition allocator, bound to the top level
// depends on fpa_pkg and fit_partition_allocator_unit_defines.svh
`include "fit_partition_allocator_unit_defines.svh"

module fpa_checker
    import fpa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);

    // a stalled result beat holds
    `FPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // one item in flight: the beat after an accept is always stalled
    `FPA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

    // no grant means no block index and no leftover
    `FPA_ASSERT_NOW(a_no_grant_zero, out_valid && !out_data.granted, out_data.granted_block == 4'd0 && out_data.block_waste == 16'd0)

endmodule

bind fit_partition_allocator_unit fpa_checker u_fpa_checker (.*);
